[hdl/glb_pkg.sv]
// Shared types, codes and helpers of the greedy line breaker.
`default_nettype none
package glb_pkg;

    // character classes; codes above CLS_END are taken as printable
    localparam logic [2:0] CLS_PRINT = 3'd0;
    localparam logic [2:0] CLS_BLANK = 3'd1;
    localparam logic [2:0] CLS_LF    = 3'd2;
    localparam logic [2:0] CLS_CR    = 3'd3;
    localparam logic [2:0] CLS_END   = 3'd4;

    localparam logic [15:0] WRAP_WIDTH_RESET = 16'd640;

    // most lines one character can close
    localparam int LINES_PER_CHAR = 3;
    // bundles held between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [15:0] first_pos;
        logic [15:0] line_end;
        logic [15:0] px_width;
        logic [15:0] line_index;
        logic        text_done;
    } t_line;

    // all lines closed by one character, oldest in lines[0]
    typedef struct packed {
        logic [1:0]                 count;
        t_line [LINES_PER_CHAR-1:0] lines;
    } t_bundle;

    function automatic logic [15:0] sat16(input logic [17:0] v);
        logic [15:0] r;
        r = (v > 18'd65535) ? 16'hFFFF : v[15:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/glb_front.sv]
// Front end: classifies each character, tracks line/word state, builds line bundles.
`default_nettype none
module glb_front #(
    parameter int MAX_TEXT_LENGTH = 65536
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [15:0]       i_wr_data,
    input  wire logic              i_valid,
    input  wire logic [2:0]        i_char_class,
    input  wire logic [7:0]        i_advance,
    input  wire logic              i_full,
    output logic                   o_stall,
    output logic                   o_push,
    output glb_pkg::t_bundle       o_bundle
);
    import glb_pkg::*;

    localparam logic [15:0] POS_CAP =
        16'((MAX_TEXT_LENGTH - 1) < 65535 ? (MAX_TEXT_LENGTH - 1) : 65535);

    typedef enum logic [1:0] {
        BRK_NONE = 2'd0,
        BRK_LF   = 2'd1,
        BRK_CR   = 2'd2
    } t_brk;

    logic [15:0] r_wrap_width;
    logic [15:0] r_pos,       n_pos;
    logic [15:0] r_line_begin, n_line_begin;
    logic [15:0] r_word_begin, n_word_begin;
    logic [15:0] r_committed, n_committed;
    logic [15:0] r_gap,       n_gap;
    logic [15:0] r_gap_last,  n_gap_last;
    logic [15:0] r_word_sum,  n_word_sum;
    logic        r_in_word,   n_in_word;
    t_brk        r_prev_brk,  n_prev_brk;
    logic [15:0] r_lines,     n_lines;

    logic        accept;
    logic        is_print;
    logic        do_fw;
    logic [17:0] total;
    logic        fw_over;
    logic        word_over;
    logic [1:0]  n_fw;
    logic [15:0] lb1, cw1, gap1, gl1, ws1;
    logic        inw1;
    logic [15:0] pos_inc;
    logic [15:0] tail_idx;
    logic        tail_emit;
    logic [1:0]  n_total;
    t_brk        kind;
    t_line       fw_a, fw_b, tail;
    logic [15:0] ws_base;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        is_print = !(i_char_class == CLS_BLANK || i_char_class == CLS_LF ||
                     i_char_class == CLS_CR || i_char_class == CLS_END);
        do_fw    = !is_print && r_in_word;
        total    = {2'b00, r_committed} + {2'b00, r_gap} + {2'b00, r_word_sum};
        fw_over  = total > {2'b00, r_wrap_width};
        word_over = r_word_sum > r_wrap_width;
        pos_inc  = (r_pos < POS_CAP) ? r_pos + 16'd1 : r_pos;

        fw_a.first_pos  = r_line_begin;
        fw_a.line_end   = r_word_begin;
        fw_a.px_width   = sat16({2'b00, r_committed} + {2'b00, r_gap_last});
        fw_a.line_index = r_lines;
        fw_a.text_done  = 1'b0;
        fw_b.first_pos  = r_word_begin;
        fw_b.line_end   = r_pos;
        fw_b.px_width   = r_word_sum;
        fw_b.line_index = r_lines + 16'd1;
        fw_b.text_done  = 1'b0;

        // word ends on any non-printable character
        n_fw = 2'd0;
        lb1  = r_line_begin;
        cw1  = r_committed;
        gap1 = r_gap;
        gl1  = r_gap_last;
        ws1  = r_word_sum;
        inw1 = r_in_word;
        if (do_fw) begin
            if (fw_over) begin
                n_fw = 2'd1;
                lb1  = r_word_begin;
                cw1  = r_word_sum;
                if (word_over) begin
                    // overlong word gets a line of its own
                    n_fw = 2'd2;
                    lb1  = r_pos;
                    cw1  = 16'd0;
                end
            end else begin
                cw1 = sat16(total);
            end
            gap1 = 16'd0;
            gl1  = 16'd0;
            ws1  = 16'd0;
            inw1 = 1'b0;
        end

        tail_idx  = r_lines + {14'd0, n_fw};
        tail_emit = 1'b0;
        tail.first_pos  = lb1;
        tail.line_end   = r_pos;
        tail.px_width   = sat16({2'b00, cw1} + {2'b00, gap1});
        tail.line_index = tail_idx;
        tail.text_done  = 1'b0;
        kind    = (i_char_class == CLS_LF) ? BRK_LF : BRK_CR;
        ws_base = inw1 ? ws1 : 16'd0;

        n_pos        = r_pos;
        n_line_begin = lb1;
        n_word_begin = r_word_begin;
        n_committed  = cw1;
        n_gap        = gap1;
        n_gap_last   = gl1;
        n_word_sum   = ws1;
        n_in_word    = inw1;
        n_prev_brk   = r_prev_brk;

        unique case (i_char_class)
            CLS_BLANK: begin
                n_gap_last = gap1;
                n_gap      = sat16({2'b00, gap1} + {10'd0, i_advance});
                n_prev_brk = BRK_NONE;
                n_pos      = pos_inc;
            end
            CLS_LF, CLS_CR: begin
                if (r_prev_brk != BRK_NONE && r_prev_brk != kind) begin
                    // second half of a CR/LF pair
                    n_prev_brk   = BRK_NONE;
                    n_pos        = pos_inc;
                    n_line_begin = pos_inc;
                end else begin
                    tail_emit    = 1'b1;
                    n_pos        = pos_inc;
                    n_line_begin = pos_inc;
                    n_committed  = 16'd0;
                    n_gap        = 16'd0;
                    n_gap_last   = 16'd0;
                    n_prev_brk   = kind;
                end
            end
            CLS_END: begin
                tail_emit      = 1'b1;
                tail.text_done = 1'b1;
                n_pos          = 16'd0;
                n_line_begin   = 16'd0;
                n_word_begin   = 16'd0;
                n_committed    = 16'd0;
                n_gap          = 16'd0;
                n_gap_last     = 16'd0;
                n_word_sum     = 16'd0;
                n_in_word      = 1'b0;
                n_prev_brk     = BRK_NONE;
            end
            default: begin
                if (!inw1) begin
                    n_word_begin = r_pos;
                end
                n_word_sum = sat16({2'b00, ws_base} + {10'd0, i_advance});
                n_in_word  = 1'b1;
                n_prev_brk = BRK_NONE;
                n_pos      = pos_inc;
            end
        endcase

        n_total = n_fw + {1'b0, tail_emit};
        n_lines = (i_char_class == CLS_END) ? 16'd0 : r_lines + {14'd0, n_total};

        // pack lines oldest first
        o_bundle.count    = n_total;
        o_bundle.lines[0] = (n_fw != 2'd0) ? fw_a : tail;
        o_bundle.lines[1] = (n_fw == 2'd2) ? fw_b : tail;
        o_bundle.lines[2] = tail;
        o_push            = accept && (n_total != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_width <= WRAP_WIDTH_RESET;
            r_pos        <= 16'd0;
            r_line_begin <= 16'd0;
            r_word_begin <= 16'd0;
            r_committed  <= 16'd0;
            r_gap        <= 16'd0;
            r_gap_last   <= 16'd0;
            r_word_sum   <= 16'd0;
            r_in_word    <= 1'b0;
            r_prev_brk   <= BRK_NONE;
            r_lines      <= 16'd0;
        end else begin
            if (i_wr_en) begin
                r_wrap_width <= i_wr_data;
            end
            if (accept) begin
                r_pos        <= n_pos;
                r_line_begin <= n_line_begin;
                r_word_begin <= n_word_begin;
                r_committed  <= n_committed;
                r_gap        <= n_gap;
                r_gap_last   <= n_gap_last;
                r_word_sum   <= n_word_sum;
                r_in_word    <= n_in_word;
                r_prev_brk   <= n_prev_brk;
                r_lines      <= n_lines;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/glb_queue.sv]
// Short bundle queue between the front end and the output side.
`default_nettype none
module glb_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire glb_pkg::t_bundle  i_bundle,
    input  wire logic              i_pop,
    output logic                   o_full,
    output logic                   o_not_empty,
    output glb_pkg::t_bundle       o_head
);
    import glb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_bundle            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_pop;

    assign o_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

[hdl/glb_back.sv]
// Output side: takes one bundle at a time and sends its lines out one line per cycle while i_stall is low.
`default_nettype none
module glb_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_not_empty,
    input  wire glb_pkg::t_bundle  i_head,
    output logic                   o_pop,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output logic [15:0]            o_first_pos,
    output logic [15:0]            o_line_end,
    output logic [15:0]            o_px_width,
    output logic [15:0]            o_line_index,
    output logic                   o_last,
    output logic                   o_text_done
);
    import glb_pkg::*;

    t_bundle     r_bundle;
    logic [1:0]  r_sub;
    logic        r_busy;
    logic        fire;
    t_line       cur;

    assign fire   = r_busy && !i_stall;
    assign o_last = (r_sub == r_bundle.count - 2'd1);
    assign o_pop  = (!r_busy || (fire && o_last)) && i_not_empty;

    always_comb begin
        unique case (r_sub)
            2'd1:    cur = r_bundle.lines[1];
            2'd2:    cur = r_bundle.lines[2];
            default: cur = r_bundle.lines[0];
        endcase
    end

    assign o_valid      = r_busy;
    assign o_first_pos  = cur.first_pos;
    assign o_line_end   = cur.line_end;
    assign o_px_width   = cur.px_width;
    assign o_line_index = cur.line_index;
    assign o_text_done  = cur.text_done;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bundle <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sub  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_sub  <= 2'd0;
        end else if (fire) begin
            if (o_last) begin
                r_busy <= 1'b0;
                r_sub  <= 2'd0;
            end else begin
                r_sub <= r_sub + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/greedy_line_breaker_core.sv]
// Greedy line breaker: streaming word wrap of classified characters into line ranges.
// Takes one character per cycle while the bundle queue has room (4 bundles).
// A character's lines go into the bundle queue when it is taken, then into the output register;
// lines leave from there one per cycle while i_stall is low.
// Synchronous active-low reset clears all text state and the queue; wrap_width returns to 640.
`default_nettype none
module greedy_line_breaker_core #(
    parameter int MAX_TEXT_LENGTH = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr_en,
    input  wire logic [15:0] i_wr_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_char_class,
    input  wire logic [7:0]  i_advance,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_first_pos,
    output logic [15:0]      o_line_end,
    output logic [15:0]      o_px_width,
    output logic [15:0]      o_line_index,
    output logic             o_last,
    output logic             o_text_done
);
    import glb_pkg::*;

    logic    q_full;
    logic    q_not_empty;
    logic    push;
    logic    pop;
    t_bundle push_bundle;
    t_bundle head_bundle;

    glb_front #(
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (i_wr_en),
        .i_wr_data    (i_wr_data),
        .i_valid      (i_valid),
        .i_char_class (i_char_class),
        .i_advance    (i_advance),
        .i_full       (q_full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_bundle     (push_bundle)
    );

    glb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_bundle    (push_bundle),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_head      (head_bundle)
    );

    glb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_not_empty  (q_not_empty),
        .i_head       (head_bundle),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_first_pos  (o_first_pos),
        .o_line_end   (o_line_end),
        .o_px_width   (o_px_width),
        .o_line_index (o_line_index),
        .o_last       (o_last),
        .o_text_done  (o_text_done)
    );

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for greedy_line_breaker_core: random text streams against a line predictor.
module tb;
    import glb_pkg::*;

    localparam int          MAX_TEXT_LENGTH = 65536;
    localparam int unsigned POS_MAX = (MAX_TEXT_LENGTH - 1 < 65535) ? MAX_TEXT_LENGTH - 1 : 65535;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 120;

    // classes above CLS_END are read as printable
    localparam logic [2:0] CLS_ODD5 = 3'd5;
    localparam logic [2:0] CLS_ODD6 = 3'd6;
    localparam logic [2:0] CLS_ODD7 = 3'd7;

    typedef enum logic [1:0] {BRK_NONE, BRK_LF, BRK_CR} t_brk;
    typedef enum logic [1:0] {ST_NONE, ST_LIGHT, ST_HEAVY, ST_PERIODIC} t_stall_mode;

    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] adv;
    } t_char_item;

    typedef struct {
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic [15:0] width_px;
        logic [15:0] index;
        logic        is_last;
        logic        done;
    } t_line_rec;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_wr_en      = 1'b0;
    logic [15:0] i_wr_data    = '0;
    logic        i_valid      = 1'b0;
    logic [2:0]  i_char_class = '0;
    logic [7:0]  i_advance    = '0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_first_pos;
    logic [15:0] o_line_end;
    logic [15:0] o_px_width;
    logic [15:0] o_line_index;
    logic        o_last;
    logic        o_text_done;

    greedy_line_breaker_core #(
        .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (i_wr_en),
        .i_wr_data    (i_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_char_class (i_char_class),
        .i_advance    (i_advance),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_first_pos  (o_first_pos),
        .o_line_end   (o_line_end),
        .o_px_width   (o_px_width),
        .o_line_index (o_line_index),
        .o_last       (o_last),
        .o_text_done  (o_text_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    t_char_item  pending_chars[$];
    t_line_rec   expected_lines[$];
    int          n_err      = 0;
    int          n_taken    = 0;
    int          n_checked  = 0;
    int          n_settings = 0;
    int          n_cycles   = 0;
    bit          hold_req   = 1'b0;

    // ---------------- line predictor ----------------
    int unsigned wrap_w = WRAP_WIDTH_RESET;
    int unsigned pos, ln_begin, wd_begin, used_w, gap_w, gap_w_prev, word_w, n_lines;
    bit          in_word;
    t_brk        last_brk = BRK_NONE;
    t_line_rec   batch[LINES_PER_CHAR];
    int          n_batch;

    function automatic int unsigned clip16(input int unsigned v);
        return (v > 65535) ? 65535 : v;
    endfunction

    task automatic clear_text();
        pos = 0; ln_begin = 0; wd_begin = 0; used_w = 0; gap_w = 0;
        gap_w_prev = 0; word_w = 0; in_word = 1'b0; last_brk = BRK_NONE; n_lines = 0;
    endtask

    task automatic step_pos();
        if (pos < POS_MAX) pos++;
    endtask

    task automatic add_line(input int unsigned s, input int unsigned e, input int unsigned w,
                            input bit done);
        batch[n_batch].start_pos = s[15:0];
        batch[n_batch].end_pos   = e[15:0];
        batch[n_batch].width_px  = clip16(w);
        batch[n_batch].index     = n_lines[15:0];
        batch[n_batch].is_last   = 1'b0;
        batch[n_batch].done      = done;
        n_lines = (n_lines + 1) & 32'hFFFF;
        n_batch++;
    endtask

    task automatic close_word();
        int unsigned total;
        total = used_w + gap_w + word_w;
        if (total > wrap_w) begin
            // line ends before the word, dropping the width of the last blank
            add_line(ln_begin, wd_begin, clip16(used_w + gap_w_prev), 1'b0);
            ln_begin = wd_begin;
            used_w = word_w;
            if (word_w > wrap_w) begin
                add_line(wd_begin, pos, word_w, 1'b0);
                ln_begin = pos;
                used_w = 0;
            end
        end else begin
            used_w = clip16(total);
        end
        gap_w = 0; gap_w_prev = 0; word_w = 0; in_word = 1'b0;
    endtask

    task automatic predict_lines(input logic [2:0] cls, input logic [7:0] adv);
        logic [2:0] c;
        t_brk       kind;
        c = (cls > CLS_END) ? CLS_PRINT : cls;
        n_batch = 0;
        if (c != CLS_PRINT && in_word) close_word();
        case (c)
            CLS_PRINT: begin
                if (!in_word) begin
                    wd_begin = pos;
                    word_w = 0;
                    in_word = 1'b1;
                end
                word_w = clip16(word_w + adv);
                last_brk = BRK_NONE;
                step_pos();
            end
            CLS_BLANK: begin
                gap_w_prev = gap_w;
                gap_w = clip16(gap_w + adv);
                last_brk = BRK_NONE;
                step_pos();
            end
            CLS_LF, CLS_CR: begin
                kind = (c == CLS_LF) ? BRK_LF : BRK_CR;
                if (last_brk != BRK_NONE && last_brk != kind) begin
                    // second half of a CR/LF pair: no line of its own
                    last_brk = BRK_NONE;
                    step_pos();
                    ln_begin = pos;
                end else begin
                    add_line(ln_begin, pos, clip16(used_w + gap_w), 1'b0);
                    step_pos();
                    ln_begin = pos;
                    used_w = 0; gap_w = 0; gap_w_prev = 0;
                    last_brk = kind;
                end
            end
            default: begin
                used_w = clip16(used_w + gap_w);
                add_line(ln_begin, pos, used_w, 1'b1);
                clear_text();
            end
        endcase
        if (n_batch > 0) batch[n_batch-1].is_last = 1'b1;
        for (int i = 0; i < n_batch; i++) expected_lines.push_back(batch[i]);
    endtask

    initial clear_text();

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : drv
        t_char_item itm;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_lines(i_char_class, i_advance);
                n_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_chars.size() > 0) begin
                    itm = pending_chars.pop_front();
                    i_valid      <= 1'b1;
                    i_char_class <= itm.cls;
                    i_advance    <= itm.adv;
                    if (burst_left <= 0)
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                                 : $urandom_range(1, 8);
                    burst_left--;
                    if (burst_left == 0) gap_left = $urandom_range(0, 6);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    t_stall_mode stall_mode = ST_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;
    bit          hold_done  = 1'b0;
    int          period_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            // long hold-off: block must fill and stall its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(10, 60);
            end else begin
                mode_left--;
            end
            period_cnt++;
            case (stall_mode)
                ST_NONE:     i_stall <= 1'b0;
                ST_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                ST_HEAVY:    i_stall <= ($urandom_range(0, 9) < 6);
                ST_PERIODIC: i_stall <= (period_cnt % 3 == 0);
                default:     i_stall <= 1'b0;
            endcase
        end
    end

    // ---------------- monitor ----------------
    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        n_err++;
        if (n_err <= 40)
            $display("mismatch %s: got %0d, expected %0d (line %0d)", what, got, want, n_checked);
    endtask

    always @(posedge i_clk) begin : mon
        t_line_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_lines.size() == 0) begin
                flag_mismatch("unexpected line, start", o_first_pos, 0);
            end else begin
                want = expected_lines.pop_front();
                if (o_first_pos !== want.start_pos)
                    flag_mismatch("start", o_first_pos, want.start_pos);
                if (o_line_end !== want.end_pos)
                    flag_mismatch("end", o_line_end, want.end_pos);
                if (o_px_width !== want.width_px)
                    flag_mismatch("width", o_px_width, want.width_px);
                if (o_line_index !== want.index)
                    flag_mismatch("index", o_line_index, want.index);
                if (o_last !== want.is_last)
                    flag_mismatch("last", o_last, want.is_last);
                if (o_text_done !== want.done)
                    flag_mismatch("text_done", o_text_done, want.done);
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d lines outstanding", n_cycles,
                     expected_lines.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic put_char(input logic [2:0] cls, input logic [7:0] adv);
        t_char_item itm;
        itm.cls = cls;
        itm.adv = adv;
        pending_chars.push_back(itm);
    endtask

    function automatic logic [7:0] pick_adv();
        case ($urandom_range(0, 19))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(2, 24));
        endcase
    endfunction

    // one text: mostly words, gaps and breaks, a little noise, then end of text
    task automatic gen_text(inout int added);
        int target, cnt, len;
        target = $urandom_range(4, 25);
        cnt = 0;
        while (cnt < target) begin
            case ($urandom_range(0, 99)) inside
                [0:54]: begin
                    len = $urandom_range(1, 7);
                    for (int i = 0; i < len; i++)
                        put_char(($urandom_range(0, 14) == 0) ? 3'($urandom_range(5, 7))
                                                              : CLS_PRINT, pick_adv());
                    cnt += len;
                end
                [55:79]: begin
                    len = $urandom_range(1, 3);
                    for (int i = 0; i < len; i++) put_char(CLS_BLANK, pick_adv());
                    cnt += len;
                end
                [80:91]: begin
                    case ($urandom_range(0, 5))
                        0: begin put_char(CLS_LF, pick_adv()); cnt += 1; end
                        1: begin put_char(CLS_CR, pick_adv()); cnt += 1; end
                        2: begin put_char(CLS_CR, pick_adv()); put_char(CLS_LF, pick_adv());
                                 cnt += 2; end
                        3: begin put_char(CLS_LF, pick_adv()); put_char(CLS_CR, pick_adv());
                                 cnt += 2; end
                        4: begin put_char(CLS_LF, pick_adv()); put_char(CLS_LF, pick_adv());
                                 cnt += 2; end
                        default: begin
                            put_char(CLS_LF, pick_adv()); put_char(CLS_CR, pick_adv());
                            put_char(CLS_LF, pick_adv()); cnt += 3;
                        end
                    endcase
                end
                default: begin
                    len = $urandom_range(1, 3);
                    for (int i = 0; i < len; i++)
                        put_char(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                    cnt += len;
                end
            endcase
        end
        put_char(CLS_END, 8'($urandom_range(0, 255)));
        added += cnt + 1;
    endtask

    task automatic fill_random(input int n);
        int added;
        added = 0;
        while (added < n) gen_text(added);
    endtask

    // waits until the block has drained, then idles for DRAIN_CYCLES
    task automatic wait_idle();
        while (pending_chars.size() > 0 || i_valid || expected_lines.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_wrap(input logic [15:0] v);
        @(posedge i_clk);
        i_wr_en   <= 1'b1;
        i_wr_data <= v;
        @(posedge i_clk);
        i_wr_en <= 1'b0;
        wrap_w = v;
        n_settings++;
        @(negedge i_clk);
    endtask

    initial begin : seq
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset width: empty text, extreme advances, odd classes, break pairs
        put_char(CLS_END, 8'd0);
        put_char(CLS_PRINT, 8'd255);
        put_char(CLS_PRINT, 8'd0);
        put_char(CLS_BLANK, 8'd255);
        put_char(CLS_ODD5, 8'd10);
        put_char(CLS_ODD6, 8'd10);
        put_char(CLS_ODD7, 8'd10);
        put_char(CLS_LF, 8'd255);
        put_char(CLS_CR, 8'd0);
        put_char(CLS_CR, 8'd3);
        put_char(CLS_LF, 8'd3);
        put_char(CLS_LF, 8'd0);
        put_char(CLS_LF, 8'd0);
        put_char(CLS_CR, 8'd0);
        put_char(CLS_LF, 8'd0);
        put_char(CLS_CR, 8'd0);
        put_char(CLS_BLANK, 8'd7);
        put_char(CLS_PRINT, 8'd3);
        put_char(CLS_END, 8'd255);
        wait_idle();

        // narrow line: word moved down, then an overlong word on its own line
        write_wrap(16'd20);
        put_char(CLS_PRINT, 8'd10);
        put_char(CLS_BLANK, 8'd5);
        put_char(CLS_BLANK, 8'd6);
        put_char(CLS_PRINT, 8'd15);
        put_char(CLS_BLANK, 8'd1);
        put_char(CLS_PRINT, 8'd30);
        put_char(CLS_END, 8'd0);
        wait_idle();

        write_wrap(16'd0);
        fill_random(22);
        wait_idle();

        // widest setting: nothing wraps
        write_wrap(16'hFFFF);
        fill_random(22);
        put_char(CLS_BLANK, 8'd255);
        put_char(CLS_BLANK, 8'd255);
        put_char(CLS_PRINT, 8'd1);
        put_char(CLS_END, 8'd0);
        wait_idle();

        write_wrap(16'd120);
        hold_req = 1'b1;
        fill_random(40);
        wait_idle();

        write_wrap(16'd300);
        fill_random(22);
        wait_idle();

        write_wrap(16'($urandom_range(20, 200)));
        fill_random(22);
        wait_idle();

        write_wrap(WRAP_WIDTH_RESET);
        fill_random(22);
        wait_idle();

        $display("covered %0d characters and %0d lines over %0d width writes plus reset width",
                 n_taken, n_checked, n_settings);
        $display("with random sender bursts, receiver stall patterns and one long hold-off");
        if (n_err == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hdl/glb_pkg.sv
hdl/glb_front.sv
hdl/glb_queue.sv
hdl/glb_back.sv
hdl/greedy_line_breaker_core.sv
bench/tb.sv
